>>> rtl/post_dispatch_latency_tracker_defines.svh
// Assertion macros used by the latency tracker top level.
`ifndef POST_DISPATCH_LATENCY_TRACKER_DEFINES_SVH
`define POST_DISPATCH_LATENCY_TRACKER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PDLT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PDLT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pdlt_pkg.sv
// Types, sizes and codes of the post-to-dispatch latency tracker.
package pdlt_pkg;

	localparam int MAX_OBJECTS = 16;
	localparam int RING_SLOTS  = 8;
	localparam int MAX_SAMPLES = 1024;

	localparam int SLOT_W     = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
	localparam int USED_W     = $clog2(MAX_OBJECTS + 1);
	localparam int PTR_W      = $clog2(RING_SLOTS);
	localparam int PEND_DEPTH = MAX_OBJECTS * RING_SLOTS;
	localparam int PEND_AW    = $clog2(PEND_DEPTH);
	localparam int STORE_AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);

	typedef enum logic [2:0] {
		OP_POST     = 3'd0,
		OP_CANCEL   = 3'd1,
		OP_DISPATCH = 3'd2,
		OP_READ     = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		STS_DONE       = 3'd0,
		STS_NULL_ID    = 3'd1,
		STS_TABLE_FULL = 3'd2,
		STS_RING_FULL  = 3'd3,
		STS_NOTHING    = 3'd4,
		STS_STORE_FULL = 3'd5,
		STS_BAD_INDEX  = 3'd6
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] object_id;
		logic [31:0] event_code;
		logic [63:0] timestamp;
		logic [9:0]  read_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  object_slot;
		logic [63:0] post_time;
		logic [63:0] dispatch_time;
		logic [63:0] latency;
		logic [31:0] sample_event;
		logic [10:0] samples_held;
	} rsp_t;

	typedef struct packed {
		logic [63:0]       post_time;
		logic [63:0]       dispatch_time;
		logic [31:0]       event_code;
		logic [SLOT_W-1:0] slot;
	} sample_t;

endpackage

>>> rtl/pdlt_ram.sv
// Generic single-port synchronous RAM with registered read.
module pdlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                             wdata,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

>>> rtl/post_dispatch_latency_tracker.sv
// Top level of the post-to-dispatch latency tracker.
//
//  channel  direction  handshake             word
//  req      in         req_valid/req_stall   pdlt_pkg::req_t
//  rsp      out        rsp_valid/rsp_stall   pdlt_pkg::rsp_t
//
// Each word does tag compare and memory reads in the accept cycle, then update and
// write-back in the finish cycle; the single port of each RAM is why these are split.
// One word is in flight at a time.
// A stalled result holds the finish cycle until the output register frees up.
// Reset clears the table count, ring pointers and sample count; no clearing pass.
`include "post_dispatch_latency_tracker_defines.svh"

module post_dispatch_latency_tracker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pdlt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pdlt_pkg::rsp_t  rsp
);
	import pdlt_pkg::*;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_SLOTS - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(RING_SLOTS - 1) : PTR_W'(p - 1'b1);
	endfunction

	function automatic logic [PEND_AW-1:0] pend_addr(input logic [SLOT_W-1:0] s,
		input logic [PTR_W-1:0] p);
		return PEND_AW'(32'(s) * RING_SLOTS + 32'(p));
	endfunction

	state_t              state_q, state_d;
	logic                accept, commit;

	logic [31:0]         tags_q [MAX_OBJECTS];
	logic [USED_W-1:0]   used_q;
	logic [PTR_W-1:0]    head_q [MAX_OBJECTS];
	logic [PTR_W-1:0]    tail_q [MAX_OBJECTS];
	logic [CNT_W-1:0]    count_q;

	logic                hit;
	logic [SLOT_W-1:0]   hit_slot, look_slot;
	logic [PTR_W-1:0]    head_look, tail_look;

	req_t                req_s1;
	logic                hit_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [PTR_W-1:0]    head_s1, tail_s1;

	logic                pend_we;
	logic [PEND_AW-1:0]  pend_a;
	logic [63:0]         pend_rdata;
	logic                st_we;
	logic [STORE_AW-1:0] st_a;
	sample_t             st_wdata, st_rdata;

	logic                post_ok, cancel_ok, disp_ok, alloc, clear;
	logic [CNT_W-1:0]    count_d;
	rsp_t                rsp_d, rsp_q;
	logic                rsp_valid_q;

	assign accept = req_valid && !req_stall;

	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = MAX_OBJECTS - 1; i >= 0; i--) begin
			if (USED_W'(i) < used_q && tags_q[i] == req.object_id) begin
				hit      = 1'b1;
				hit_slot = SLOT_W'(i);
			end
		end
	end

	assign look_slot = hit ? hit_slot : SLOT_W'(used_q);
	assign head_look = hit ? head_q[hit_slot] : '0;
	assign tail_look = hit ? tail_q[hit_slot] : '0;

	always_comb begin
		state_d   = state_q;
		commit    = 1'b0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				commit = !rsp_valid_q || !rsp_stall;
				if (commit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_d     = '0;
		post_ok   = 1'b0;
		cancel_ok = 1'b0;
		disp_ok   = 1'b0;
		alloc     = 1'b0;
		clear     = 1'b0;
		rsp_d.status = STS_DONE;
		if (req_s1.operation <= OP_DISPATCH && req_s1.object_id == '0) begin
			rsp_d.status = STS_NULL_ID;
		end else begin
			unique case (req_s1.operation)
				OP_POST: begin
					if (!hit_s1 && used_q >= USED_W'(MAX_OBJECTS)) begin
						rsp_d.status = STS_TABLE_FULL;
					end else begin
						alloc             = !hit_s1;
						rsp_d.object_slot = 4'(slot_s1);
						if (ptr_inc(head_s1) == tail_s1) begin
							rsp_d.status = STS_RING_FULL;
						end else begin
							post_ok         = 1'b1;
							rsp_d.post_time = req_s1.timestamp;
						end
					end
				end
				OP_CANCEL: begin
					if (!hit_s1 || head_s1 == tail_s1) begin
						rsp_d.status = STS_NOTHING;
					end else begin
						cancel_ok         = 1'b1;
						rsp_d.object_slot = 4'(slot_s1);
					end
				end
				OP_DISPATCH: begin
					if (!hit_s1 || head_s1 == tail_s1) begin
						rsp_d.status = STS_NOTHING;
					end else if (count_q >= CNT_W'(MAX_SAMPLES)) begin
						rsp_d.status = STS_STORE_FULL;
					end else begin
						disp_ok             = 1'b1;
						rsp_d.object_slot   = 4'(slot_s1);
						rsp_d.post_time     = pend_rdata;
						rsp_d.dispatch_time = req_s1.timestamp;
						rsp_d.latency       = req_s1.timestamp - pend_rdata;
						rsp_d.sample_event  = req_s1.event_code;
					end
				end
				OP_READ: begin
					if (32'(req_s1.read_index) >= 32'(count_q)) begin
						rsp_d.status = STS_BAD_INDEX;
					end else begin
						rsp_d.object_slot   = 4'(st_rdata.slot);
						rsp_d.post_time     = st_rdata.post_time;
						rsp_d.dispatch_time = st_rdata.dispatch_time;
						rsp_d.latency       = st_rdata.dispatch_time - st_rdata.post_time;
						rsp_d.sample_event  = st_rdata.event_code;
					end
				end
				OP_CLEAR: begin
					clear = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (disp_ok) begin
			count_d = CNT_W'(count_q + 1'b1);
		end else if (clear) begin
			count_d = '0;
		end else begin
			count_d = count_q;
		end
		rsp_d.samples_held = 11'(count_d);
	end

	assign pend_we = commit && post_ok;
	assign pend_a  = pend_we ? pend_addr(slot_s1, head_s1) : pend_addr(look_slot, tail_look);

	pdlt_ram #(
		.WIDTH (64),
		.DEPTH (PEND_DEPTH)
	) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.re    (accept),
		.addr  (pend_a),
		.wdata (req_s1.timestamp),
		.rdata (pend_rdata)
	);

	assign st_we = commit && disp_ok;
	assign st_a  = st_we ? STORE_AW'(count_q) : STORE_AW'(req.read_index);

	always_comb begin
		st_wdata.post_time     = pend_rdata;
		st_wdata.dispatch_time = req_s1.timestamp;
		st_wdata.event_code    = req_s1.event_code;
		st_wdata.slot          = slot_s1;
	end

	pdlt_ram #(
		.WIDTH ($bits(sample_t)),
		.DEPTH (MAX_SAMPLES)
	) u_store_ram (
		.clk   (clk),
		.we    (st_we),
		.re    (accept),
		.addr  (st_a),
		.wdata (st_wdata),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			count_q     <= '0;
			head_q      <= '{default: '0};
			tail_q      <= '{default: '0};
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
				if (clear) begin
					used_q <= '0;
				end else if (alloc) begin
					used_q <= USED_W'(used_q + 1'b1);
				end
				if (alloc) begin
					tail_q[slot_s1] <= '0;
				end
				if (post_ok) begin
					head_q[slot_s1] <= ptr_inc(head_s1);
				end
				if (cancel_ok) begin
					head_q[slot_s1] <= ptr_dec(head_s1);
				end
				if (disp_ok) begin
					tail_q[slot_s1] <= ptr_inc(tail_s1);
				end
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req;
			hit_s1  <= hit;
			slot_s1 <= look_slot;
			head_s1 <= head_look;
			tail_s1 <= tail_look;
		end
		if (commit) begin
			rsp_q <= rsp_d;
			if (alloc) begin
				tags_q[slot_s1] <= req_s1.object_id;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`PDLT_ASSERT_NEXT(a_accept_to_fin, accept, state_q == ST_FIN, "accept did not enter finish")
	`PDLT_ASSERT_NEXT(a_commit_valid, commit, rsp_valid_q, "result not presented after commit")
	`PDLT_ASSERT_NOW(a_used_bound, 1'b1, used_q <= USED_W'(MAX_OBJECTS), "table count overrun")
	`PDLT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_SAMPLES), "sample count overrun")

endmodule

>>> tb/sv/latency_tracker_checker.sv
// Checker for the latency tracker: predicts each result and compares it with the block's output.
module latency_tracker_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  pdlt_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  pdlt_pkg::rsp_t rsp,
	output int             fails,
	output int             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import pdlt_pkg::*;

	logic [31:0]      tag_of_slot [MAX_OBJECTS];
	int               slots_taken;
	logic [63:0]      pending_ts [PEND_DEPTH];
	logic [PTR_W-1:0] push_ptr [MAX_OBJECTS];
	logic [PTR_W-1:0] pop_ptr [MAX_OBJECTS];
	sample_t          samples [MAX_SAMPLES];
	int               samples_taken;
	rsp_t             expected_results [$];

	function automatic rsp_t track_word(input req_t w);
		rsp_t             r;
		int               hit;
		logic [PTR_W-1:0] nxt;
		r = '0;
		hit = MAX_OBJECTS;
		for (int i = 0; i < slots_taken; i++) begin
			if (hit == MAX_OBJECTS && tag_of_slot[i] == w.object_id) begin
				hit = i;
			end
		end
		if (w.operation <= OP_DISPATCH && w.object_id == '0) begin
			r.status = STS_NULL_ID;
		end else begin
			case (w.operation)
				OP_POST: begin
					if (hit == MAX_OBJECTS) begin
						if (slots_taken >= MAX_OBJECTS) begin
							r.status = STS_TABLE_FULL;
						end else begin
							hit = slots_taken;
							tag_of_slot[hit] = w.object_id;
							push_ptr[hit] = '0;
							pop_ptr[hit] = '0;
							slots_taken++;
						end
					end
					if (r.status == STS_DONE) begin
						r.object_slot = SLOT_W'(hit);
						nxt = push_ptr[hit] + 1'b1;
						if (nxt == pop_ptr[hit]) begin
							r.status = STS_RING_FULL;
						end else begin
							pending_ts[hit * RING_SLOTS + push_ptr[hit]] = w.timestamp;
							push_ptr[hit] = nxt;
							r.post_time = w.timestamp;
						end
					end
				end
				OP_CANCEL: begin
					if (hit == MAX_OBJECTS || push_ptr[hit] == pop_ptr[hit]) begin
						r.status = STS_NOTHING;
					end else begin
						r.object_slot = SLOT_W'(hit);
						push_ptr[hit] = push_ptr[hit] - 1'b1;
					end
				end
				OP_DISPATCH: begin
					if (hit == MAX_OBJECTS || push_ptr[hit] == pop_ptr[hit]) begin
						r.status = STS_NOTHING;
					end else if (samples_taken >= MAX_SAMPLES) begin
						r.status = STS_STORE_FULL;
					end else begin
						r.post_time = pending_ts[hit * RING_SLOTS + pop_ptr[hit]];
						pop_ptr[hit] = pop_ptr[hit] + 1'b1;
						r.dispatch_time = w.timestamp;
						r.latency = r.dispatch_time - r.post_time;
						r.sample_event = w.event_code;
						r.object_slot = SLOT_W'(hit);
						samples[samples_taken].post_time = r.post_time;
						samples[samples_taken].dispatch_time = r.dispatch_time;
						samples[samples_taken].event_code = w.event_code;
						samples[samples_taken].slot = SLOT_W'(hit);
						samples_taken++;
					end
				end
				OP_READ: begin
					if (w.read_index >= samples_taken) begin
						r.status = STS_BAD_INDEX;
					end else begin
						r.post_time = samples[w.read_index].post_time;
						r.dispatch_time = samples[w.read_index].dispatch_time;
						r.latency = r.dispatch_time - r.post_time;
						r.sample_event = samples[w.read_index].event_code;
						r.object_slot = samples[w.read_index].slot;
					end
				end
				OP_CLEAR: begin
					slots_taken = 0;
					samples_taken = 0;
				end
				default: begin
				end
			endcase
		end
		r.samples_held = CNT_W'(samples_taken);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (got_v !== want_v) begin
			fails++;
			$error("%s: expected %0h, got %0h", field, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			slots_taken = 0;
			samples_taken = 0;
			foreach (push_ptr[i]) begin
				push_ptr[i] = '0;
				pop_ptr[i] = '0;
			end
			expected_results.delete();
			fails = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got = rsp;
				if (expected_results.size() == 0) begin
					fails++;
					$error("result word with no expectation waiting");
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, got.status);
					check_field("object_slot", want.object_slot, got.object_slot);
					check_field("post_time", want.post_time, got.post_time);
					check_field("dispatch_time", want.dispatch_time, got.dispatch_time);
					check_field("latency", want.latency, got.latency);
					check_field("sample_event", want.sample_event, got.sample_event);
					check_field("samples_held", want.samples_held, got.samples_held);
				end
			end
			if (req_valid && !req_stall) begin
				expected_results.push_back(track_word(req));
			end
			outstanding = expected_results.size();
		end
	end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the latency tracker: clock, reset, stimulus, receiver stalls and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pdlt_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 600000;
	localparam int unsigned POOL         = 24;
	localparam int unsigned RANDOM_WORDS = 1000;
	localparam int unsigned FILL_PAIRS   = 60;
	localparam int unsigned CALM_WORDS   = 100;
	localparam int unsigned HOLD_AFTER   = 300;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam logic [2:0]  OP_LAST_CODE = '1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	int          fails;
	int          outstanding;
	int unsigned sent_count = 0;
	int unsigned cycles = 0;
	int unsigned gap_pct = 0;
	bit          calm = 1'b0;
	bit          hold_done = 1'b0;
	logic [63:0] now_us = 64'd1000;
	logic [31:0] id_pool [POOL];

	post_dispatch_latency_tracker DUT (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	latency_tracker_checker track_check (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.fails,
		.outstanding
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int unsigned pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 5;
			2: return 15;
			default: return 35;
		endcase
	endfunction

	function automatic req_t make_word(input logic [2:0] op, input logic [31:0] id,
			input logic [31:0] ev, input logic [63:0] ts, input logic [9:0] idx);
		req_t w;
		w.operation = op;
		w.object_id = id;
		w.event_code = ev;
		w.timestamp = ts;
		w.read_index = idx;
		return w;
	endfunction

	function automatic req_t random_word();
		req_t        w;
		int unsigned pick;
		now_us += $urandom_range(0, 5000);
		w.event_code = $urandom;
		w.timestamp = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : now_us;
		w.read_index = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
		if ($urandom_range(0, 29) == 0) begin
			w.object_id = '0;
		end else if ($urandom_range(0, 19) == 0) begin
			w.object_id = $urandom;
		end else begin
			w.object_id = id_pool[$urandom_range(0, POOL - 1)];
		end
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			w.operation = OP_POST;
		end else if (pick < 72) begin
			w.operation = OP_DISPATCH;
		end else if (pick < 82) begin
			w.operation = OP_CANCEL;
		end else if (pick < 95) begin
			w.operation = OP_READ;
		end else if (pick < 97) begin
			w.operation = OP_CLEAR;
		end else begin
			w.operation = 3'($urandom_range(OP_CLEAR + 1, OP_LAST_CODE));
		end
		return w;
	endfunction

	task automatic send_word(input req_t w);
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent_count++;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned rx_pct;
		int unsigned rx_left;
		rx_pct = 0;
		rx_left = 0;
		@(posedge clk);
		forever begin
			if (rx_left == 0) begin
				rx_pct = pick_pct();
				rx_left = $urandom_range(50, 400);
			end
			if (!hold_done && sent_count >= HOLD_AFTER) begin
				hold_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end
			rx_left--;
		end
	end

	initial begin
		logic [31:0] id;
		for (int k = 0; k < POOL; k++) begin
			id_pool[k] = $urandom_range(32'h7FFF_FFFF, 1);
		end
		wait (arst_n === 1'b1);
		@(posedge clk);

		send_word(make_word(OP_POST, '0, '0, '0, '0));
		send_word(make_word(OP_CANCEL, '0, '0, '0, '0));
		send_word(make_word(OP_DISPATCH, '0, '0, '0, '0));
		send_word(make_word(OP_READ, '0, '0, '0, '0));
		send_word(make_word(OP_CANCEL, '1, '0, '0, '0));
		send_word(make_word(OP_DISPATCH, '1, '0, '0, '0));
		send_word(make_word(OP_POST, '1, '0, '1, '0));
		send_word(make_word(OP_POST, '1, '0, '0, '0));
		for (int k = 0; k < 5; k++) begin
			send_word(make_word(OP_POST, '1, '0, 64'd100 + k, '0));
		end
		send_word(make_word(OP_POST, '1, '0, 64'd200, '0));
		send_word(make_word(OP_CANCEL, '1, '0, '0, '0));
		send_word(make_word(OP_DISPATCH, '1, '1, 64'd5, '0));
		send_word(make_word(OP_DISPATCH, '1, '0, '1, '1));
		send_word(make_word(OP_READ, '0, '0, '0, '0));
		send_word(make_word(OP_READ, '0, '0, '0, '1));
		for (int k = OP_CLEAR + 1; k <= OP_LAST_CODE; k++) begin
			send_word(make_word(3'(k), $urandom, $urandom, {$urandom, $urandom}, 10'($urandom)));
		end
		send_word(make_word(OP_CLEAR, '0, '0, '0, '0));

		for (int k = 0; k < RANDOM_WORDS; k++) begin
			if (k % 100 == 0) begin
				gap_pct = pick_pct();
			end
			send_word(random_word());
		end

		// post and dispatch in pairs across every table slot
		send_word(make_word(OP_CLEAR, '0, '0, '0, '0));
		for (int k = 0; k < FILL_PAIRS; k++) begin
			if (k % 100 == 0) begin
				gap_pct = pick_pct();
			end
			id = id_pool[k % MAX_OBJECTS];
			now_us += $urandom_range(1, 3000);
			send_word(make_word(OP_POST, id, '0, now_us, '0));
			now_us += $urandom_range(0, 3000);
			send_word(make_word(OP_DISPATCH, id, $urandom, now_us, '0));
		end
		send_word(make_word(OP_DISPATCH, '1, '0, now_us, '0));
		send_word(make_word(OP_READ, '0, '0, '0, '1));
		send_word(make_word(OP_READ, '0, '0, '0, '0));
		send_word(make_word(OP_READ, '0, '0, '0, 10'($urandom)));

		calm = 1'b1;
		for (int k = 0; k < CALM_WORDS; k++) begin
			send_word(random_word());
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/pdlt_pkg.sv
rtl/pdlt_ram.sv
rtl/post_dispatch_latency_tracker.sv
tb/sv/latency_tracker_checker.sv
tb/sv/tb.sv
